FILE: src/rrh_pkg.sv
// Package for the region-of-interest rebinned histogram.
// Holds command, status and register-index codes and the fixed register widths.
// No dependencies.
`default_nettype none

package rrh_pkg;

  // Fixed widths of the configuration registers and the command and status fields.
  localparam int CFG_COORD_BITS = 16;
  localparam int SPAN_BITS      = 5;
  localparam int SHIFT_BITS     = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  // Input commands. The unused code is treated as a plain read.
  localparam cmd_t CMD_COUNT      = 2'd0;
  localparam cmd_t CMD_READ       = 2'd1;
  localparam cmd_t CMD_READ_CLEAR = 2'd2;

  // Result status codes.
  localparam status_t ST_COUNTED = 2'd0;
  localparam status_t ST_OUTSIDE = 2'd1;
  localparam status_t ST_BEYOND  = 2'd2;
  localparam status_t ST_READ    = 2'd3;

  // Configuration register indexes.
  localparam cfg_index_t CFG_X_LOW       = 3'd0;
  localparam cfg_index_t CFG_X_HIGH      = 3'd1;
  localparam cfg_index_t CFG_Y_LOW       = 3'd2;
  localparam cfg_index_t CFG_Y_SPAN_LOG2 = 3'd3;
  localparam cfg_index_t CFG_REBIN_SHIFT = 3'd4;

endpackage

`default_nettype wire

FILE: src/rrh_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module rrh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/rrh_bin_map.sv
// Maps one input word to its status and counter address: box test, span test,
// rebin shift and store-range check. Depends on rrh_pkg.
`default_nettype none

module rrh_bin_map
  import rrh_pkg::*;
#(
  parameter int COORD_BITS    = 16,
  parameter int BIN_ADDR_BITS = 12
) (
  input  wire cmd_t                     command,
  input  wire logic [COORD_BITS-1:0]    event_x,
  input  wire logic [COORD_BITS-1:0]    event_y,
  input  wire logic [BIN_ADDR_BITS-1:0] read_bin,
  input  wire logic [CFG_COORD_BITS-1:0] x_low,
  input  wire logic [CFG_COORD_BITS-1:0] x_high,
  input  wire logic [CFG_COORD_BITS-1:0] y_low,
  input  wire logic [SPAN_BITS-1:0]     y_span_log2,
  input  wire logic [SHIFT_BITS-1:0]    rebin_shift,
  output status_t                       status,
  output logic      [BIN_ADDR_BITS-1:0] bin_addr
);

  logic [COORD_BITS-1:0] xl;
  logic [COORD_BITS-1:0] xh;
  logic [COORD_BITS-1:0] yl;
  logic [COORD_BITS-1:0] dy;
  logic [COORD_BITS-1:0] bin;
  logic [SHIFT_BITS-1:0] shift_eff;
  logic                  in_x;
  logic                  y_ge;
  logic                  in_span;
  logic                  beyond;

  // Box bounds are taken modulo the coordinate width.
  always_comb begin
    xl = COORD_BITS'(x_low);
    xh = COORD_BITS'(x_high);
    yl = COORD_BITS'(y_low);
    in_x = (event_x >= xl) && (event_x < xh);
    y_ge = (event_y >= yl);
    dy = event_y - yl;
    // A shift past the vector width leaves zero, so a large span admits all.
    in_span = ((dy >> y_span_log2) == '0);
    shift_eff = (SPAN_BITS'(rebin_shift) >= y_span_log2) ? '0 : rebin_shift;
    bin = dy >> shift_eff;
    beyond = ((bin >> BIN_ADDR_BITS) != '0);
  end

  // Classify the word.
  always_comb begin
    status = ST_READ;
    bin_addr = read_bin;
    if (command == CMD_COUNT) begin
      if (!in_x || !y_ge || !in_span) begin
        status = ST_OUTSIDE;
        bin_addr = '0;
      end else if (beyond) begin
        status = ST_BEYOND;
        bin_addr = '0;
      end else begin
        status = ST_COUNTED;
        bin_addr = BIN_ADDR_BITS'(bin);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/roi_rebinned_histogram_unit.sv
// Region-of-interest event histogram with power-of-two rebinning.
// Top level: configuration registers, sequencer and output register.
// Depends on rrh_pkg, rrh_ram and rrh_bin_map.
//
// Usage:
//   The input channel (in_valid/in_stall) carries one command word: count an
//   event (x, y), read one bin, or read and clear one bin. Each word gives
//   exactly one result word on the output channel (out_valid/out_stall):
//   status, bin index and count.
//   The counters live in one RAM with a registered read port. A word is
//   decoded in the cycle after it is accepted, its bin is read there, and in
//   the next cycle the counter is updated and written back. The result is
//   loaded into the output register behind out_valid once that is free. A new
//   word is taken while the previous one is written back and the output
//   register is free, but not during decode, set by the read-modify-write
//   through the counter RAM. After reset the block sweeps the RAM to zero,
//   one counter per cycle (2^BIN_ADDR_BITS counters, 4096 by default), with
//   in_stall high; the configuration port works then. Configuration must
//   be written only while the block is idle; the block does not enforce it.
//   When the receiver stalls, the result waits in the output register and one
//   more finished result waits inside; the block then stalls its input.
`default_nettype none

module roi_rebinned_histogram_unit
  import rrh_pkg::*;
#(
  parameter int COORD_BITS    = 16,
  parameter int BIN_ADDR_BITS = 12,
  parameter int COUNT_BITS    = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Configuration port.
  input  wire logic                      cfg_we,
  input  wire cfg_index_t                cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  // Input channel.
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire cmd_t                      in_command,
  input  wire logic [COORD_BITS-1:0]     in_event_x,
  input  wire logic [COORD_BITS-1:0]     in_event_y,
  input  wire logic [BIN_ADDR_BITS-1:0]  in_read_bin,
  // Output channel.
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output status_t                        out_status,
  output logic      [BIN_ADDR_BITS-1:0]  out_bin_index,
  output logic      [COUNT_BITS-1:0]     out_bin_count
);

  localparam int DEPTH = 1 << BIN_ADDR_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_MODIFY = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  // Configuration registers.
  logic [CFG_COORD_BITS-1:0] x_low_r;
  logic [CFG_COORD_BITS-1:0] x_high_r;
  logic [CFG_COORD_BITS-1:0] y_low_r;
  logic [SPAN_BITS-1:0]      y_span_log2_r;
  logic [SHIFT_BITS-1:0]     rebin_shift_r;

  // Sequencer and clearing sweep.
  logic [1:0]               state_r;
  logic [1:0]               state_nxt;
  logic                     clr_active_r;
  logic [BIN_ADDR_BITS-1:0] clr_addr_r;

  // Accepted word.
  cmd_t                     cmd_r;
  logic [COORD_BITS-1:0]    ex_r;
  logic [COORD_BITS-1:0]    ey_r;
  logic [BIN_ADDR_BITS-1:0] rbin_r;

  // Decoded operation.
  status_t                  map_status;
  logic [BIN_ADDR_BITS-1:0] map_addr;
  status_t                  op_status_r;
  logic [BIN_ADDR_BITS-1:0] op_addr_r;
  logic                     op_clear_r;

  // Result path.
  logic [COUNT_BITS-1:0]    ram_rdata;
  logic [COUNT_BITS-1:0]    res_count;
  logic [COUNT_BITS-1:0]    hold_count_r;
  status_t                  hold_status_r;
  logic [BIN_ADDR_BITS-1:0] hold_index_r;
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [BIN_ADDR_BITS-1:0] out_index_r;
  logic [COUNT_BITS-1:0]    out_count_r;

  // RAM write port.
  logic                     ram_we;
  logic [BIN_ADDR_BITS-1:0] ram_waddr;
  logic [COUNT_BITS-1:0]    ram_wdata;

  logic out_free;
  logic in_accept;
  logic load_from_modify;
  logic load_from_hold;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r       <= '0;
      x_high_r      <= '0;
      y_low_r       <= '0;
      y_span_log2_r <= '0;
      rebin_shift_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_LOW:       x_low_r       <= cfg_wdata;
        CFG_X_HIGH:      x_high_r      <= cfg_wdata;
        CFG_Y_LOW:       y_low_r       <= cfg_wdata;
        CFG_Y_SPAN_LOG2: y_span_log2_r <= cfg_wdata[SPAN_BITS-1:0];
        CFG_REBIN_SHIFT: rebin_shift_r <= cfg_wdata[SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and sequencing.
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    in_stall = clr_active_r ||
               !((state_r == S_IDLE) || ((state_r == S_MODIFY) && out_free));
    in_accept = in_valid && !in_stall;
    load_from_modify = (state_r == S_MODIFY) && out_free;
    load_from_hold = (state_r == S_HOLD) && out_free;

    state_nxt = state_r;
    case (state_r)
      S_IDLE:   state_nxt = in_accept ? S_DECODE : S_IDLE;
      S_DECODE: state_nxt = S_MODIFY;
      S_MODIFY: begin
        if (!out_free) begin
          state_nxt = S_HOLD;
        end else if (in_accept) begin
          state_nxt = S_DECODE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_HOLD:   state_nxt = out_free ? S_IDLE : S_HOLD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == BIN_ADDR_BITS'(DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
    end
  end

  // Capture the accepted word.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= in_command;
      ex_r   <= in_event_x;
      ey_r   <= in_event_y;
      rbin_r <= in_read_bin;
    end
  end

  rrh_bin_map #(
    .COORD_BITS    (COORD_BITS),
    .BIN_ADDR_BITS (BIN_ADDR_BITS)
  ) u_bin_map (
    .command     (cmd_r),
    .event_x     (ex_r),
    .event_y     (ey_r),
    .read_bin    (rbin_r),
    .x_low       (x_low_r),
    .x_high      (x_high_r),
    .y_low       (y_low_r),
    .y_span_log2 (y_span_log2_r),
    .rebin_shift (rebin_shift_r),
    .status      (map_status),
    .bin_addr    (map_addr)
  );

  // Keep the decoded operation for the write-back cycle.
  always_ff @(posedge clk) begin
    if (state_r == S_DECODE) begin
      op_status_r <= map_status;
      op_addr_r   <= map_addr;
      op_clear_r  <= (cmd_r == CMD_READ_CLEAR);
    end
  end

  // Counter update and RAM write: the clearing sweep or the write-back.
  always_comb begin
    case (op_status_r)
      ST_COUNTED: res_count = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
      ST_READ:    res_count = ram_rdata;
      default:    res_count = '0;
    endcase

    ram_we = 1'b0;
    ram_waddr = op_addr_r;
    ram_wdata = res_count;
    if (clr_active_r) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (state_r == S_MODIFY) begin
      if (op_status_r == ST_COUNTED) begin
        ram_we = 1'b1;
      end else if ((op_status_r == ST_READ) && op_clear_r) begin
        ram_we = 1'b1;
        ram_wdata = '0;
      end
    end
  end

  rrh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_counters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (map_addr),
    .rdata (ram_rdata)
  );

  // A finished result waits here while the output register is full.
  always_ff @(posedge clk) begin
    if ((state_r == S_MODIFY) && !out_free) begin
      hold_status_r <= op_status_r;
      hold_index_r  <= op_addr_r;
      hold_count_r  <= res_count;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_from_modify || load_from_hold) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_modify) begin
      out_status_r <= op_status_r;
      out_index_r  <= op_addr_r;
      out_count_r  <= res_count;
    end else if (load_from_hold) begin
      out_status_r <= hold_status_r;
      out_index_r  <= hold_index_r;
      out_count_r  <= hold_count_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_bin_index = out_index_r;
  assign out_bin_count = out_count_r;

endmodule

`default_nettype wire

FILE: verif/roi_rebinned_histogram_unit_test.sv
// Self-checking testbench for roi_rebinned_histogram_unit: directed table, then random phases.
// Each accepted word goes through an in-bench histogram model; results are checked against it or the table.
// Depends on rrh_pkg and the roi_rebinned_histogram_unit RTL.
`default_nettype none

module roi_rebinned_histogram_unit_test
  import rrh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS    = 16;
  localparam int BIN_ADDR_BITS = 12;
  localparam int COUNT_BITS    = 32;
  localparam int HIST_DEPTH    = 1 << BIN_ADDR_BITS;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_WORDS   = 140;
  localparam int QUIET_PHASES  = 2;

  // The spare command code behaves as a plain read.
  localparam cmd_t CMD_READ_ALT = 2'd3;

  typedef struct packed {
    status_t                  status;
    logic [BIN_ADDR_BITS-1:0] bin;
    logic [COUNT_BITS-1:0]    count;
  } hist_result_t;

  typedef struct {
    bit                       setup;
    logic [15:0]              x_low;
    logic [15:0]              x_high;
    logic [15:0]              y_low;
    logic [4:0]               span;
    logic [3:0]               shift;
    cmd_t                     cmd;
    logic [COORD_BITS-1:0]    ex;
    logic [COORD_BITS-1:0]    ey;
    logic [BIN_ADDR_BITS-1:0] rb;
    bit                       typed;
    hist_result_t             want;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  cfg_index_t               cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  cmd_t                     in_command;
  logic [COORD_BITS-1:0]    in_event_x;
  logic [COORD_BITS-1:0]    in_event_y;
  logic [BIN_ADDR_BITS-1:0] in_read_bin;
  logic                     out_valid;
  logic                     out_stall;
  status_t                  out_status;
  logic [BIN_ADDR_BITS-1:0] out_bin_index;
  logic [COUNT_BITS-1:0]    out_bin_count;

  // Histogram model state: box settings and the bin counters.
  logic [15:0]           roi_x_low, roi_x_high, roi_y_low;
  logic [4:0]            roi_span;
  logic [3:0]            roi_shift;
  logic [COUNT_BITS-1:0] bin_counts [HIST_DEPTH];

  hist_result_t pending_results[$];
  stim_row_t    stim_rows[$];

  int send_gap_pct;
  int recv_stall_pct;
  int error_count;
  int words_sent;
  int settings_loaded;
  int status_seen [4];

  roi_rebinned_histogram_unit #(
    .COORD_BITS   (COORD_BITS),
    .BIN_ADDR_BITS(BIN_ADDR_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_event_x   (in_event_x),
    .in_event_y   (in_event_y),
    .in_read_bin  (in_read_bin),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_bin_index(out_bin_index),
    .out_bin_count(out_bin_count)
  );

  always #5 clk = ~clk;

  // Applies one word to the histogram model and returns the result it should produce.
  function automatic hist_result_t predict_histogram(cmd_t cmd, logic [15:0] ex,
                                                     logic [15:0] ey,
                                                     logic [BIN_ADDR_BITS-1:0] rb);
    hist_result_t r;
    int unsigned  ydelta;
    int unsigned  eff_shift;
    int unsigned  bin;
    logic [BIN_ADDR_BITS-1:0] bin_addr;
    r = '0;
    if (cmd != CMD_COUNT) begin
      r.status = ST_READ;
      r.bin    = rb;
      r.count  = bin_counts[rb];
      if (cmd == CMD_READ_CLEAR) bin_counts[rb] = '0;
    end else if (!(ex >= roi_x_low && ex < roi_x_high) || ey < roi_y_low) begin
      r.status = ST_OUTSIDE;
    end else begin
      ydelta = 32'(ey) - 32'(roi_y_low);
      if ((ydelta >> roi_span) != 0) begin
        r.status = ST_OUTSIDE;
      end else begin
        eff_shift = (roi_shift >= roi_span) ? 0 : roi_shift;
        bin = ydelta >> eff_shift;
        if (bin >= HIST_DEPTH) begin
          r.status = ST_BEYOND;
        end else begin
          bin_addr = bin[BIN_ADDR_BITS-1:0];
          // Counters stick at all ones.
          if (bin_counts[bin_addr] != '1) bin_counts[bin_addr] = bin_counts[bin_addr] + 1'b1;
          r.status = ST_COUNTED;
          r.bin    = bin_addr;
          r.count  = bin_counts[bin_addr];
        end
      end
    end
    return r;
  endfunction

  function automatic void add_setup_row(logic [15:0] xl, logic [15:0] xh, logic [15:0] yl,
                                        logic [4:0] span, logic [3:0] shift);
    stim_row_t row;
    row = '{default: '0};
    row.setup  = 1'b1;
    row.x_low  = xl;
    row.x_high = xh;
    row.y_low  = yl;
    row.span   = span;
    row.shift  = shift;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_word_row(cmd_t cmd, logic [15:0] ex, logic [15:0] ey,
                                       logic [BIN_ADDR_BITS-1:0] rb);
    stim_row_t row;
    row = '{default: '0};
    row.cmd = cmd;
    row.ex  = ex;
    row.ey  = ey;
    row.rb  = rb;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_checked_row(cmd_t cmd, logic [15:0] ex, logic [15:0] ey,
                                          logic [BIN_ADDR_BITS-1:0] rb, status_t st,
                                          logic [BIN_ADDR_BITS-1:0] bin,
                                          logic [COUNT_BITS-1:0] count);
    stim_row_t row;
    row = '{default: '0};
    row.cmd   = cmd;
    row.ex    = ex;
    row.ey    = ey;
    row.rb    = rb;
    row.typed = 1'b1;
    row.want  = '{status: st, bin: bin, count: count};
    stim_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    error_count++;
    if (error_count <= 50)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Writes all five box registers, one per cycle, while the block is idle.
  task automatic load_settings(logic [15:0] xl, logic [15:0] xh, logic [15:0] yl,
                               logic [4:0] span, logic [3:0] shift);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_X_LOW;
    cfg_wdata <= xl;
    @(posedge clk);
    cfg_index <= CFG_X_HIGH;
    cfg_wdata <= xh;
    @(posedge clk);
    cfg_index <= CFG_Y_LOW;
    cfg_wdata <= yl;
    @(posedge clk);
    cfg_index <= CFG_Y_SPAN_LOG2;
    cfg_wdata <= CFG_DATA_BITS'(span);
    @(posedge clk);
    cfg_index <= CFG_REBIN_SHIFT;
    cfg_wdata <= CFG_DATA_BITS'(shift);
    @(posedge clk);
    cfg_we <= 1'b0;
    roi_x_low  = xl;
    roi_x_high = xh;
    roi_y_low  = yl;
    roi_span   = span;
    roi_shift  = shift;
    settings_loaded++;
  endtask

  // Offers one word, holds it until accepted, then queues its predicted result.
  task automatic send_word(cmd_t cmd, logic [15:0] ex, logic [15:0] ey,
                           logic [BIN_ADDR_BITS-1:0] rb, bit typed, hist_result_t want);
    hist_result_t model;
    if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_event_x  <= ex;
    in_event_y  <= ey;
    in_read_bin <= rb;
    do @(posedge clk); while (in_stall);
    model = predict_histogram(cmd, ex, ey, rb);
    pending_results.push_back(typed ? want : model);
    words_sent++;
  endtask

  // Stops offering words and waits for every outstanding result.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Receiver back-pressure in random bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    hist_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      status_seen[out_status]++;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending, bin_index", out_bin_index, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_bin_index !== want.bin)
          report_mismatch("bin_index", out_bin_index, want.bin);
        if (out_bin_count !== want.count)
          report_mismatch("bin_count", out_bin_count, want.count);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #3ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned  xl, xh, yl, span, shift, eff_shift, top, pick;
    logic [15:0]  ex, ey;
    logic [BIN_ADDR_BITS-1:0] rb;
    cmd_t         cmd;
    hist_result_t none;

    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_X_LOW;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_command     = CMD_COUNT;
    in_event_x     = '0;
    in_event_y     = '0;
    in_read_bin    = '0;
    send_gap_pct   = 25;
    recv_stall_pct = 25;
    error_count    = 0;
    words_sent     = 0;
    none           = '0;
    roi_x_low      = '0;
    roi_x_high     = '0;
    roi_y_low      = '0;
    roi_span       = '0;
    roi_shift      = '0;
    foreach (bin_counts[i]) bin_counts[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. Reset settings leave an empty x range, so nothing counts.
    add_checked_row(CMD_COUNT, 16'h0000, 16'h0000, 12'd0, ST_OUTSIDE, 12'd0, 32'd0);
    add_checked_row(CMD_READ, 16'h0000, 16'h0000, 12'd0, ST_READ, 12'd0, 32'd0);
    add_checked_row(CMD_READ, 16'hFFFF, 16'hFFFF, 12'hFFF, ST_READ, 12'hFFF, 32'd0);
    // Small window with rebinning: edges of the box on every side.
    add_setup_row(16'h0000, 16'hFFFF, 16'h0100, 5'd4, 4'd1);
    add_checked_row(CMD_COUNT, 16'h0000, 16'h0100, 12'd0, ST_COUNTED, 12'd0, 32'd1);
    add_word_row(CMD_COUNT, 16'hFFFE, 16'h010F, 12'd0);
    add_checked_row(CMD_COUNT, 16'hFFFF, 16'h0100, 12'd0, ST_OUTSIDE, 12'd0, 32'd0);
    add_checked_row(CMD_COUNT, 16'h0000, 16'h00FF, 12'd0, ST_OUTSIDE, 12'd0, 32'd0);
    add_checked_row(CMD_COUNT, 16'h0000, 16'h0110, 12'd0, ST_OUTSIDE, 12'd0, 32'd0);
    add_checked_row(CMD_READ_CLEAR, 16'h0000, 16'h0000, 12'd0, ST_READ, 12'd0, 32'd1);
    add_checked_row(CMD_READ, 16'h0000, 16'h0000, 12'd0, ST_READ, 12'd0, 32'd0);
    add_word_row(CMD_READ_ALT, 16'h0000, 16'h0000, 12'd7);
    // Empty x range with equal bounds and the largest span.
    add_setup_row(16'h1234, 16'h1234, 16'h0000, 5'd16, 4'd0);
    add_checked_row(CMD_COUNT, 16'h1234, 16'h0000, 12'd0, ST_OUTSIDE, 12'd0, 32'd0);
    // Full span without rebinning: bins past the store are dropped.
    add_setup_row(16'h0000, 16'hFFFF, 16'h0000, 5'd16, 4'd0);
    add_checked_row(CMD_COUNT, 16'h0000, 16'hFFFF, 12'd0, ST_BEYOND, 12'd0, 32'd0);
    add_word_row(CMD_COUNT, 16'h7FFF, 16'h0FFF, 12'd0);
    add_checked_row(CMD_COUNT, 16'h0001, 16'h1000, 12'd0, ST_BEYOND, 12'd0, 32'd0);
    // Top corner of the coordinate space with the largest rebin shift.
    add_setup_row(16'hFFFE, 16'hFFFF, 16'hFFFF, 5'd16, 4'd15);
    add_word_row(CMD_COUNT, 16'hFFFE, 16'hFFFF, 12'd0);
    add_checked_row(CMD_COUNT, 16'hFFFE, 16'hFFFE, 12'd0, ST_OUTSIDE, 12'd0, 32'd0);
    // Zero span: a shift not below the span falls back to no shift.
    add_setup_row(16'h0000, 16'hFFFF, 16'h8000, 5'd0, 4'd15);
    add_word_row(CMD_COUNT, 16'h5555, 16'h8000, 12'd0);
    add_checked_row(CMD_COUNT, 16'hAAAA, 16'h8001, 12'd0, ST_OUTSIDE, 12'd0, 32'd0);
    add_word_row(CMD_READ_CLEAR, 16'h0000, 16'h0000, 12'hAAA);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].setup) begin
        drain_results();
        load_settings(stim_rows[i].x_low, stim_rows[i].x_high, stim_rows[i].y_low,
                      stim_rows[i].span, stim_rows[i].shift);
      end else begin
        send_word(stim_rows[i].cmd, stim_rows[i].ex, stim_rows[i].ey, stim_rows[i].rb,
                  stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random phases, each under its own box settings. Counter saturation is out of
    // reach at this count width within the run.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          xl = 0; xh = 16'hFFFF; yl = 0; span = 16; shift = 15;
        end
        1: begin
          xl = $urandom_range(0, 100); xh = $urandom_range(16'hFFFF, 60000);
          yl = $urandom_range(0, 16'hFFFF); span = 0; shift = $urandom_range(0, 15);
        end
        2: begin
          xl = 16'hFFFF; xh = 0; yl = $urandom_range(0, 16'hFFFF);
          span = $urandom_range(0, 16); shift = $urandom_range(0, 15);
        end
        3: begin
          xl = 0; xh = 16'hFFFF; yl = $urandom_range(0, 255);
          span = $urandom_range(13, 16); shift = $urandom_range(0, 2);
        end
        default: begin
          xl = $urandom_range(0, 40000);
          xh = ($urandom_range(0, 7) == 0) ? $urandom_range(xl, 0)
                                           : $urandom_range(16'hFFFF, xl + 1);
          yl = $urandom_range(0, 16'hFFFF);
          span = $urandom_range(0, 16); shift = $urandom_range(0, 15);
        end
      endcase
      load_settings(16'(xl), 16'(xh), 16'(yl), 5'(span), 4'(shift));

      if (ph >= NUM_PHASES - QUIET_PHASES) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end else begin
        send_gap_pct   = 25 * $urandom_range(0, 2);
        recv_stall_pct = 25 * $urandom_range(0, 2);
      end

      eff_shift = (shift >= span) ? 0 : shift;
      top = (span >= 16) ? 16'hFFFF : yl + (1 << span) - 1;
      if (top > 16'hFFFF) top = 16'hFFFF;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Start from an event inside the box; noise and reads reuse or replace it.
        ex = (xl < xh) ? 16'($urandom_range(xh - 1, xl)) : 16'($urandom_range(0, 16'hFFFF));
        ey = 16'($urandom_range(top, yl));
        rb = BIN_ADDR_BITS'((ey - yl) >> eff_shift);
        cmd = CMD_COUNT;
        pick = $urandom_range(0, 99);
        if (pick >= 60 && pick < 70) begin
          ex = 16'($urandom_range(0, 16'hFFFF));
          ey = 16'($urandom_range(0, 16'hFFFF));
        end else if (pick >= 70) begin
          cmd = (pick < 82) ? CMD_READ : (pick < 94) ? CMD_READ_CLEAR : CMD_READ_ALT;
          if ($urandom_range(0, 3) == 0) rb = BIN_ADDR_BITS'($urandom_range(0, HIST_DEPTH - 1));
          ex = 16'($urandom_range(0, 16'hFFFF));
          ey = 16'($urandom_range(0, 16'hFFFF));
        end
        send_word(cmd, ex, ey, rb, 1'b0, none);
      end
    end

    // Let the last results drain, with a bound.
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && pending_results.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());

    $display("Sent %0d words under %0d register settings.", words_sent, settings_loaded);
    $display("Results: %0d counted, %0d outside box, %0d beyond store, %0d reads.",
             status_seen[ST_COUNTED], status_seen[ST_OUTSIDE], status_seen[ST_BEYOND],
             status_seen[ST_READ]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
